>>> src/tbc_pkg.sv
`default_nettype none

package tbc_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] OP_LOOKUP     = 2'd0;
    localparam logic [1:0] OP_INSERT     = 2'd1;
    localparam logic [1:0] OP_INVALIDATE = 2'd2;

    typedef struct packed {
        logic [63:0] start;
        logic [11:0] length;
        logic [15:0] handle;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic match;
        logic decide;
        logic sweep;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic do_sweep;
        logic sweep_done;
        logic out_free;
    } stat_t;

    // index of the set bit of a one-hot (or zero) vector
    function automatic logic [IDX_W-1:0] onehot_index(input logic [TABLE_ENTRIES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (v[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> src/tbc_ctrl.sv
`default_nettype none

module tbc_ctrl
    import tbc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MATCH  = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = stat.do_sweep ? S_SWEEP : S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_FINISH;
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> src/tbc_dp.sv
`default_nettype none

module tbc_dp
    import tbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] guest_address,
    input  wire logic [15:0] block_handle,
    input  wire logic [11:0] block_bytes,
    input  wire logic [31:0] range_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [15:0]      found_handle,
    output logic             status,
    output logic [31:0]      hits_so_far,
    output logic [31:0]      misses_so_far
);

    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);

    // request held for the whole operation
    logic [1:0]  op_reg;
    logic [63:0] addr_reg;
    logic [63:0] end_reg;
    logic [15:0] handle_reg;
    logic [11:0] bytes_reg;
    logic        do_sweep_reg;

    // tag cells compare in parallel; the rest of an entry sits in the memory
    logic [63:0]              tag_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] match_reg;
    logic [TABLE_ENTRIES-1:0] free_reg;
    logic [TABLE_ENTRIES-1:0] match_vec;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    logic [CNT_W-1:0] sweep_cnt_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic             eval_en_reg;

    logic        pend_hit_reg;
    logic [15:0] pend_handle_reg;
    logic        pend_status_reg;

    logic        out_valid_reg;
    logic        hit_reg;
    logic [15:0] found_reg;
    logic        status_reg;
    logic [31:0] hit_cnt_reg;
    logic [31:0] miss_cnt_reg;

    logic [TABLE_ENTRIES-1:0] free_low;
    logic [IDX_W-1:0]         match_idx;
    logic [IDX_W-1:0]         free_idx;
    logic                     any_match;
    logic                     any_free;
    logic [IDX_W-1:0]         slot;
    logic                     ins_write;
    logic                     is_lookup;
    logic                     sweep_issue;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_idx;
    logic [63:0]              entry_end;
    logic                     clr;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (tag_reg[i] == addr_reg);
        end
    end

    assign free_low  = free_reg & (~free_reg + TABLE_ENTRIES'(1));
    assign match_idx = onehot_index(match_reg);
    assign free_idx  = onehot_index(free_low);
    assign any_match = |match_reg;
    assign any_free  = |free_reg;
    assign slot      = any_match ? match_idx : free_idx;
    assign is_lookup = (op_reg == OP_LOOKUP);
    assign ins_write = cmd.decide && (op_reg == OP_INSERT) && (any_match || any_free);

    assign sweep_issue = cmd.sweep && (sweep_cnt_reg < ENTRIES_CNT);
    assign rd_en       = sweep_issue || (cmd.decide && is_lookup && any_match);
    assign rd_idx      = sweep_issue ? sweep_cnt_reg[IDX_W-1:0] : match_idx;

    // overlap of the swept entry with [addr, end), wrapped sums
    assign entry_end = rd_data_reg.start + {52'd0, rd_data_reg.length};
    assign clr       = eval_en_reg && valid_reg[eval_idx_reg]
                     && (rd_data_reg.start < end_reg) && (entry_end > addr_reg);

    assign stat.do_sweep   = do_sweep_reg;
    assign stat.sweep_done = (sweep_cnt_reg == ENTRIES_CNT) && !eval_en_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= op;
            addr_reg   <= guest_address;
            end_reg    <= guest_address + {32'd0, range_bytes};
            handle_reg <= block_handle;
            bytes_reg  <= block_bytes;
        end
        if (cmd.match)
        begin
            match_reg <= match_vec;
            free_reg  <= ~valid_reg;
        end
        if (ins_write)
        begin
            tag_reg[slot] <= addr_reg;
            mem[slot]     <= '{start: addr_reg, length: bytes_reg, handle: handle_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
        if (sweep_issue)
        begin
            eval_idx_reg <= sweep_cnt_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            do_sweep_reg    <= 1'b0;
            sweep_cnt_reg   <= '0;
            eval_en_reg     <= 1'b0;
            pend_hit_reg    <= 1'b0;
            pend_handle_reg <= '0;
            pend_status_reg <= 1'b0;
        end
        else
        begin
            eval_en_reg <= sweep_issue;
            if (sweep_issue)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + CNT_W'(1);
            end
            if (ins_write)
            begin
                valid_reg[slot] <= 1'b1;
            end
            if (clr)
            begin
                valid_reg[eval_idx_reg] <= 1'b0;
            end
            if (cmd.load_in)
            begin
                do_sweep_reg    <= (op == OP_INVALIDATE) && (range_bytes != 32'd0);
                sweep_cnt_reg   <= '0;
                pend_hit_reg    <= 1'b0;
                pend_handle_reg <= '0;
                pend_status_reg <= 1'b0;
            end
            if (cmd.decide)
            begin
                if (is_lookup)
                begin
                    pend_hit_reg <= any_match;
                end
                else if (op_reg == OP_INSERT)
                begin
                    pend_handle_reg <= (any_match || any_free) ? handle_reg : 16'd0;
                    pend_status_reg <= !(any_match || any_free);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            hit_reg       <= 1'b0;
            found_reg     <= '0;
            status_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                hit_reg       <= is_lookup && pend_hit_reg;
                found_reg     <= (is_lookup && pend_hit_reg) ? rd_data_reg.handle
                                                             : pend_handle_reg;
                status_reg    <= pend_status_reg;
                if (is_lookup)
                begin
                    if (pend_hit_reg)
                    begin
                        hit_cnt_reg <= hit_cnt_reg + 32'd1;
                    end
                    else
                    begin
                        miss_cnt_reg <= miss_cnt_reg + 32'd1;
                    end
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign found_handle  = found_reg;
    assign status        = status_reg;
    assign hits_so_far   = hit_cnt_reg;
    assign misses_so_far = miss_cnt_reg;

endmodule

`default_nettype wire

>>> src/translation_block_cache.sv
// Lookup, insert and empty-range invalidate pass through the tag compare, the select and
// the registered entry-memory read, then wait until the output register is free.
// Invalidate with a nonzero size sweeps the entry memory one entry a cycle, then waits
// for the output register too; no new request is taken until the result is loaded.
// A waiting result does not block acceptance, but the next result waits behind it.
// Asynchronous active-low reset clears all valid bits and both counters at once.
`default_nettype none

module translation_block_cache
    import tbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] guest_address,
    input  wire logic [15:0] block_handle,
    input  wire logic [11:0] block_bytes,
    input  wire logic [31:0] range_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [15:0]      found_handle,
    output logic             status,
    output logic [31:0]      hits_so_far,
    output logic [31:0]      misses_so_far
);

    cmd_t  cmd;
    stat_t stat;

    tbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tbc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .op            (op),
        .guest_address (guest_address),
        .block_handle  (block_handle),
        .block_bytes   (block_bytes),
        .range_bytes   (range_bytes),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .found_handle  (found_handle),
        .status        (status),
        .hits_so_far   (hits_so_far),
        .misses_so_far (misses_so_far)
    );

endmodule

`default_nettype wire
